// ===== rtl/msme_pkg.sv =====
package msme_pkg;

    localparam int REPEAT_ENTRIES = 64;
    localparam int RPT_AW = $clog2(REPEAT_ENTRIES);
    localparam int RPT_CW = $clog2(REPEAT_ENTRIES + 1);
    localparam int MAX_BYTES = 14;

    localparam logic [27:0] DELAY_MAX = 28'hFFFFFFF;
    localparam logic [6:0] VEL_RESET = 7'd100;
    localparam logic [7:0] OP_REST = 8'h00;
    localparam logic [7:0] OP_TRANSP_SEL = 8'hE7;
    localparam logic [7:0] OP_TRANSP_SET = 8'hED;
    localparam logic [7:0] OP_VELOCITY = 8'hFE;
    localparam logic [7:0] OP_END = 8'hFF;
    localparam logic [7:0] ST_PROGRAM = 8'hC0;
    localparam logic [7:0] ST_PROGRAM_PERC = 8'hC9;
    localparam logic [7:0] ST_NOTE_ON = 8'h90;
    localparam logic [7:0] ST_NOTE_ON_PERC = 8'h99;
    localparam logic [1:0] PERC_CHANNEL = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input transaction
        logic exec;     // run command, build byte buffer
        logic scan;     // repeat table compare step
        logic rpt_hit;  // apply hit on current scan entry
        logic rpt_miss; // scan finished without a hit
        logic emit;     // present byte at index
        logic done;     // transaction finished
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_repeat;  // command needs the table
        logic scan_hit;
        logic scan_end;
        logic [3:0] nbytes;
    } t_stat;

    // pitch of an opcode with signed transpose; the sum is clamped to 0..127 before the pitch mapping
    function automatic logic [6:0] pitch_of(input logic [7:0] op, input logic [7:0] tr);
        logic signed [9:0] idx;
        logic [6:0] c;
        begin
            idx = $signed({2'b00, op}) + $signed({{2{tr[7]}}, tr});
            if (idx < 0) c = 7'd0;
            else if (idx > 127) c = 7'd127;
            else c = idx[6:0];
            if (c < 7'd16) pitch_of = 7'd0;
            else pitch_of = 7'(12 * ({4'd0, c[6:4]} + 7'd1)) + {3'd0, c[3:0]};
        end
    endfunction

endpackage

// ===== rtl/music_sequence_to_midi_events.sv =====
// channel      dir  handshake              payload
// s_axis       in   tvalid/tready          tdata, tuser=kind
// m_axis       out  tvalid/tready          tdata, tlast
// cfg          in   i_cfg_valid/o_cfg_ready  program_number
// one command at a time: load, execute, then one byte per cycle while m_axis is ready
// a note yields up to 14 bytes; other commands yield one result with no byte
// a counted repeat first searches the up to 64 filled table entries in order
// reset clears control state synchronously; the table needs no clearing
// output stalls hold the current byte; no input is taken until the last byte goes
module music_sequence_to_midi_events (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // track[1:0], start_address[17:2], opcode[25:18], argument[33:26], follow[41:34]
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // has_byte[0], out_byte[8:1], next_address[24:9], track_done[25], table_full[26]
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import msme_pkg::*;

    t_cmd w_cmd;
    t_stat w_stat;
    logic [3:0] w_idx;
    logic [7:0] w_byte;
    logic [15:0] w_addr;
    logic w_done, w_full;

    assign o_cfg_ready = 1'b1;

    msme_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(w_cmd), .i_stat(w_stat), .o_idx(w_idx), .o_last(m_axis_tlast)
    );

    msme_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_data(i_cfg_data),
        .i_kind(s_axis_tuser), .i_track(s_axis_tdata[1:0]),
        .i_start_address(s_axis_tdata[17:2]), .i_opcode(s_axis_tdata[25:18]),
        .i_argument(s_axis_tdata[33:26]), .i_follow_byte(s_axis_tdata[41:34]),
        .i_cmd(w_cmd), .o_stat(w_stat), .i_idx(w_idx),
        .o_byte(w_byte), .o_next_address(w_addr),
        .o_track_done(w_done), .o_table_full(w_full)
    );

    assign m_axis_tdata = {5'd0, w_full, w_done, w_addr, w_byte, (w_stat.nbytes != 4'd0)};
endmodule

// ===== rtl/msme_ram.sv =====
module msme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== rtl/msme_ctrl.sv =====
module msme_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output msme_pkg::t_cmd o_cmd,
    input  msme_pkg::t_stat i_stat,
    output logic [3:0]     o_idx,
    output logic           o_last
);
    import msme_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;

    logic [2:0] r_state, n_state;
    logic [3:0] r_idx, n_idx;
    logic [3:0] w_cnt;

    assign w_cnt = (i_stat.nbytes == 4'd0) ? 4'd1 : i_stat.nbytes;
    assign o_idx = r_idx;
    assign o_last = (r_idx == w_cnt - 4'd1);
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_idx = 4'd0;
                if (i_stat.is_repeat) begin
                    o_cmd.scan = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_hit) begin
                    o_cmd.rpt_hit = 1'b1;
                    n_state = S_EMIT;
                end else if (i_stat.scan_end) begin
                    o_cmd.rpt_miss = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_out_ready) begin
                    if (o_last) begin
                        o_cmd.done = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= 4'd0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
        end
    end

`ifndef SYNTH
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_idx < w_cnt)) else $error("byte index past count");
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EXEC)) else $error("load not followed by exec");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.done |=> o_in_ready) else $error("not ready after done");
`endif
endmodule

// ===== rtl/msme_dp.sv =====
module msme_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [6:0]      i_cfg_data,
    input  logic            i_kind,
    input  logic [1:0]      i_track,
    input  logic [15:0]     i_start_address,
    input  logic [7:0]      i_opcode,
    input  logic [7:0]      i_argument,
    input  logic [7:0]      i_follow_byte,
    input  msme_pkg::t_cmd  i_cmd,
    output msme_pkg::t_stat o_stat,
    input  logic [3:0]      i_idx,
    output logic [7:0]      o_byte,
    output logic [15:0]     o_next_address,
    output logic            o_track_done,
    output logic            o_table_full
);
    import msme_pkg::*;

    logic [6:0] r_program;
    logic [15:0] r_pos;
    logic [7:0] r_transpose;
    logic [6:0] r_velocity;
    logic [27:0] r_delay;
    logic r_first;
    logic [1:0] r_chan;
    logic r_ended;
    logic [REPEAT_ENTRIES-1:0] r_valid;
    logic [RPT_CW-1:0] r_fill;
    logic r_full;
    logic r_kind;
    logic [7:0] r_op, r_arg, r_follow;
    logic [7:0] r_buf [MAX_BYTES];
    logic [3:0] r_nbytes;
    logic r_scan_live;
    logic r_scan_last;
    logic [RPT_AW-1:0] r_rd_addr;
    logic [RPT_AW-1:0] w_raddr;
    logic w_first_scan;

    // repeat table, key and count packed per entry
    logic rt_we;
    logic [RPT_AW-1:0] rt_waddr;
    logic [19:0] rt_wdata, rt_rdata;

    msme_ram #(.WIDTH(20), .DEPTH(REPEAT_ENTRIES)) u_rpt (
        .i_clk(i_clk), .i_we(rt_we), .i_waddr(rt_waddr), .i_wdata(rt_wdata),
        .i_raddr(w_raddr), .o_rdata(rt_rdata)
    );

    logic w_active;
    logic [15:0] w_off;
    assign w_active = r_kind && !r_ended;
    assign w_off = {{7{r_arg[7]}}, r_arg, 1'b0};

    assign o_stat.is_repeat = w_active && (r_op >= 8'h90) && (r_op <= 8'hBF)
                              && (r_op[3:0] != 4'd0);
    assign o_stat.scan_hit = r_scan_live && r_valid[r_rd_addr] && (rt_rdata[19:4] == r_pos);
    // empty table ends the search at once
    assign o_stat.scan_end = r_scan_live ? r_scan_last : 1'b1;
    assign o_stat.nbytes = r_nbytes;

    assign o_byte = (r_nbytes == 4'd0) ? 8'd0 : r_buf[i_idx];
    assign o_next_address = r_pos;
    assign o_track_done = r_ended;
    assign o_table_full = r_full;

    // byte buffer for a note command
    logic [7:0] nb [MAX_BYTES];
    logic [3:0] nn;
    logic [6:0] w_note;
    logic [12:0] w_len;
    logic [27:0] w_rest;

    always_comb begin
        w_note = pitch_of(r_op, r_transpose);
        if (r_chan == PERC_CHANNEL) begin
            if (r_op == 8'h02) w_note = 7'd42;
            else if (r_op == 8'h03) w_note = 7'd36;
            else if (r_op == 8'h20) w_note = 7'd38;
        end
        w_len = 13'(r_arg * 5'd30);
        w_rest = r_delay + {15'd0, w_len};
        for (int k = 0; k < MAX_BYTES; k++) nb[k] = 8'd0;
        nn = 4'd0;
        // delay vlq, up to 4 groups
        if (r_delay[27:21] != 0) begin
            nb[nn] = {1'b1, r_delay[27:21]}; nn = nn + 4'd1;
        end
        if (r_delay[27:14] != 0) begin
            nb[nn] = {1'b1, r_delay[20:14]}; nn = nn + 4'd1;
        end
        if (r_delay[27:7] != 0) begin
            nb[nn] = {1'b1, r_delay[13:7]}; nn = nn + 4'd1;
        end
        nb[nn] = {1'b0, r_delay[6:0]}; nn = nn + 4'd1;
        if (r_first) begin
            nb[nn] = (r_chan == PERC_CHANNEL) ? ST_PROGRAM_PERC : (ST_PROGRAM | {6'd0, r_chan});
            nn = nn + 4'd1;
            nb[nn] = {1'b0, r_program}; nn = nn + 4'd1;
            nb[nn] = 8'd0; nn = nn + 4'd1;
            nb[nn] = (r_chan == PERC_CHANNEL) ? ST_NOTE_ON_PERC : (ST_NOTE_ON | {6'd0, r_chan});
            nn = nn + 4'd1;
        end
        nb[nn] = {1'b0, w_note}; nn = nn + 4'd1;
        nb[nn] = {1'b0, r_velocity}; nn = nn + 4'd1;
        if (w_len[12:7] != 0) begin
            nb[nn] = {2'b10, w_len[12:7]}; nn = nn + 4'd1;
        end
        nb[nn] = {1'b0, w_len[6:0]}; nn = nn + 4'd1;
        nb[nn] = {1'b0, w_note}; nn = nn + 4'd1;
        nb[nn] = 8'd0; nn = nn + 4'd1;
    end

    logic [7:0] w_v10;
    assign w_v10 = (r_arg > 8'd12) ? 8'd120 : 8'(r_arg * 4'd10);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_program <= 7'd0;
            r_pos <= 16'd0;
            r_transpose <= 8'd0;
            r_velocity <= VEL_RESET;
            r_delay <= 28'd0;
            r_first <= 1'b1;
            r_chan <= 2'd0;
            r_ended <= 1'b1;
            r_valid <= '0;
            r_fill <= '0;
            r_full <= 1'b0;
            r_nbytes <= 4'd0;
            r_scan_live <= 1'b0;
        end else begin
            if (i_cfg_valid) r_program <= i_cfg_data;
            if (i_cmd.load) begin
                r_kind <= i_kind;
                r_op <= i_opcode;
                r_arg <= i_argument;
                r_follow <= i_follow_byte;
                r_full <= 1'b0;
                r_nbytes <= 4'd0;
                if (!i_kind) begin
                    r_chan <= i_track;
                    r_pos <= i_start_address;
                    r_ended <= (i_start_address == 16'd0);
                    r_transpose <= 8'd0;
                    r_velocity <= VEL_RESET;
                    r_delay <= 28'd0;
                    r_first <= 1'b1;
                    r_valid <= '0;
                    r_fill <= '0;
                end
            end
            if (i_cmd.exec && w_active) begin
                if (r_op == OP_REST) begin
                    r_delay <= (w_rest < r_delay) ? DELAY_MAX : w_rest;
                    r_pos <= r_pos + 16'd2;
                end else if (r_op < 8'h80) begin
                    for (int k = 0; k < MAX_BYTES; k++) r_buf[k] <= nb[k];
                    r_nbytes <= nn;
                    r_first <= 1'b0;
                    r_delay <= 28'd0;
                    r_pos <= r_pos + 16'd2;
                end else if (r_op >= 8'h90 && r_op <= 8'hBF) begin
                    if (r_arg[7] || r_arg == 8'd0) r_ended <= 1'b1;
                    else if (r_op[7:4] == 4'hB && r_arg == 8'd89 && r_follow == 8'hFF)
                        r_ended <= 1'b1;
                    else r_pos <= r_pos + w_off;
                end else if (r_op == OP_TRANSP_SEL) begin
                    if (r_arg == 8'd1) r_transpose <= 8'd12;
                    else if (r_arg == 8'd0) r_transpose <= 8'd0;
                    r_pos <= r_pos + 16'd2;
                end else if (r_op == OP_TRANSP_SET) begin
                    r_transpose <= r_arg;
                    r_pos <= r_pos + 16'd2;
                end else if (r_op == OP_VELOCITY) begin
                    r_velocity <= w_v10[6:0];
                    r_pos <= r_pos + 16'd2;
                end else if (r_op == OP_END) begin
                    r_ended <= 1'b1;
                end else begin
                    r_pos <= r_pos + 16'd2;
                end
            end
            // read data of the entry at r_rd_addr is valid the cycle after a scan step
            r_scan_live <= i_cmd.scan && (r_fill != '0);
            if (i_cmd.rpt_hit) begin
                if (rt_rdata[3:0] != 4'd0) r_pos <= r_pos + w_off;
                else r_pos <= r_pos + 16'd2;
            end
            if (i_cmd.rpt_miss) begin
                if (r_fill == RPT_CW'(REPEAT_ENTRIES)) begin
                    r_full <= 1'b1;
                    r_pos <= r_pos + w_off;
                end else begin
                    r_valid[r_fill[RPT_AW-1:0]] <= 1'b1;
                    r_fill <= r_fill + RPT_CW'(1);
                end
            end
        end
    end

    // scan address: entry 0 on the first step, then one filled entry per cycle
    assign w_first_scan = i_cmd.scan && !r_scan_live;
    assign w_raddr = w_first_scan ? '0 : r_rd_addr + RPT_AW'(1);
    always_ff @(posedge i_clk) begin
        r_rd_addr <= w_raddr;
        r_scan_last <= (({1'b0, w_raddr} + RPT_CW'(1)) == r_fill);
    end

    always_comb begin
        rt_we = 1'b0;
        rt_waddr = r_rd_addr;
        rt_wdata = {r_pos, r_op[3:0]};
        if (i_cmd.rpt_hit) begin
            rt_we = 1'b1;
            rt_wdata = {rt_rdata[19:4],
                        (rt_rdata[3:0] != 4'd0) ? rt_rdata[3:0] - 4'd1 : r_op[3:0]};
        end else if (i_cmd.rpt_miss && r_fill != RPT_CW'(REPEAT_ENTRIES)) begin
            rt_we = 1'b1;
            rt_waddr = r_fill[RPT_AW-1:0];
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= RPT_CW'(REPEAT_ENTRIES)) else $error("fill past table");
    a_full_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_full) |-> $past(i_cmd.rpt_miss)) else $error("full without miss");
    a_nbytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nbytes <= 4'(MAX_BYTES)) else $error("byte count too large");
`endif
endmodule

// ===== test/music_sequence_to_midi_events_test.sv =====
`timescale 1ns / 100ps

module music_sequence_to_midi_events_test;
    import msme_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  out_byte;
        logic [15:0] next_address;
        logic        track_done;
        logic        table_full;
        logic        last;
    } t_event;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // track, start_address, opcode, argument, follow_byte (from bit 0 up)
    logic [47:0] s_axis_tdata;
    logic        s_axis_tuser;  // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // has_byte, out_byte, next_address, track_done, table_full (from bit 0 up)
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    music_sequence_to_midi_events i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // shadow of the sequencer state
    logic [6:0]  sh_program;
    logic [15:0] sh_pos;
    logic [7:0]  sh_transpose;
    logic [6:0]  sh_velocity;
    logic [27:0] sh_delay;
    logic        sh_first_note;
    logic [1:0]  sh_channel;
    logic        sh_ended;
    logic [15:0] sh_rpt_key [REPEAT_ENTRIES];
    logic [3:0]  sh_rpt_cnt [REPEAT_ENTRIES];
    logic        sh_rpt_valid [REPEAT_ENTRIES];
    int          sh_rpt_fill;

    t_event      midi_expected[$];
    int          mismatches;
    int          cycles;
    int          send_idle_pct;
    int          recv_idle_pct;

    // 2 ns high, 2 ns low
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL music_sequence_to_midi_events");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // receiver: random back-pressure, compares each result transaction
    always @(posedge i_clk) begin
        t_event got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[0], m_axis_tdata[8:1], m_axis_tdata[24:9],
                        m_axis_tdata[25], m_axis_tdata[26], m_axis_tlast};
                if (midi_expected.size() == 0) begin
                    report_mismatch("unexpected result", got, 0);
                end else begin
                    want = midi_expected.pop_front();
                    if (got.has_byte != want.has_byte)
                        report_mismatch("has_byte", got.has_byte, want.has_byte);
                    if (got.out_byte != want.out_byte)
                        report_mismatch("out_byte", got.out_byte, want.out_byte);
                    if (got.next_address != want.next_address)
                        report_mismatch("next_address", got.next_address, want.next_address);
                    if (got.track_done != want.track_done)
                        report_mismatch("track_done", got.track_done, want.track_done);
                    if (got.table_full != want.table_full)
                        report_mismatch("table_full", got.table_full, want.table_full);
                    if (got.last != want.last)
                        report_mismatch("last", got.last, want.last);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [6:0] midi_pitch(input logic [7:0] op);
        int idx;
        idx = int'(op) + int'($signed(sh_transpose));
        if (idx < 0) idx = 0;
        if (idx > 127) idx = 127;
        if (idx < 16) return 7'd0;
        return 7'(12 * ((idx >> 4) + 1) + (idx & 15));
    endfunction

    task automatic push_vlq(inout logic [7:0] buf_q[$], input logic [27:0] v);
        int groups;
        groups = 1;
        while (groups < 4 && (v >> (7 * groups)) != 0) groups++;
        for (int g = groups - 1; g >= 0; g--)
            buf_q.push_back({g != 0, 7'((v >> (7 * g)) & 28'h7F)});
    endtask

    task automatic sequence_jump(input logic [7:0] op, input logic [7:0] arg,
                                 input logic [7:0] follow, inout logic full);
        logic [15:0] off;
        off = 16'($signed(arg)) << 1;
        if (op[3:0] == 4'd0) begin
            if ($signed(arg) <= 0) sh_ended = 1'b1;
            else if (op[7:4] == 4'hB && arg == 8'd89 && follow == 8'hFF) sh_ended = 1'b1;
            else sh_pos = sh_pos + off;
            return;
        end
        for (int k = 0; k < REPEAT_ENTRIES; k++) begin
            if (sh_rpt_valid[k] && sh_rpt_key[k] == sh_pos) begin
                if (sh_rpt_cnt[k] > 0) begin
                    sh_rpt_cnt[k]--;
                    sh_pos = sh_pos + off;
                end else begin
                    sh_rpt_cnt[k] = op[3:0];
                    sh_pos = sh_pos + 16'd2;
                end
                return;
            end
        end
        if (sh_rpt_fill < REPEAT_ENTRIES) begin
            sh_rpt_key[sh_rpt_fill] = sh_pos;
            sh_rpt_cnt[sh_rpt_fill] = op[3:0];
            sh_rpt_valid[sh_rpt_fill] = 1'b1;
            sh_rpt_fill++;
        end else begin
            full = 1'b1;
            sh_pos = sh_pos + off;
        end
    endtask

    // computes the midi bytes one sequence transaction produces
    task automatic predict_midi_events(input logic kind, input logic [1:0] trk,
                                       input logic [15:0] start, input logic [7:0] op,
                                       input logic [7:0] arg, input logic [7:0] follow);
        logic [7:0] bytes_q[$];
        logic       full;
        logic [6:0] note;
        logic [28:0] sum;
        int         n;
        full = 1'b0;
        if (!kind) begin
            sh_channel = trk;
            sh_pos = start;
            sh_ended = (start == 16'd0);
            sh_transpose = 8'd0;
            sh_velocity = VEL_RESET;
            sh_delay = 28'd0;
            sh_first_note = 1'b1;
            for (int k = 0; k < REPEAT_ENTRIES; k++) sh_rpt_valid[k] = 1'b0;
            sh_rpt_fill = 0;
        end else if (!sh_ended) begin
            if (op == OP_REST) begin
                sum = {1'b0, sh_delay} + 29'(arg) * 29'd30;
                sh_delay = sum > {1'b0, DELAY_MAX} ? DELAY_MAX : sum[27:0];
                sh_pos += 16'd2;
            end else if (op < 8'h80) begin
                note = midi_pitch(op);
                if (sh_channel == PERC_CHANNEL) begin
                    if (op == 8'h02) note = 7'd42;
                    else if (op == 8'h03) note = 7'd36;
                    else if (op == 8'h20) note = 7'd38;
                end
                push_vlq(bytes_q, sh_delay);
                if (sh_first_note) begin
                    bytes_q.push_back(sh_channel == PERC_CHANNEL ? ST_PROGRAM_PERC
                                                                 : (ST_PROGRAM | {6'd0, sh_channel}));
                    bytes_q.push_back({1'b0, sh_program});
                    bytes_q.push_back(8'd0);
                    bytes_q.push_back(sh_channel == PERC_CHANNEL ? ST_NOTE_ON_PERC
                                                                 : (ST_NOTE_ON | {6'd0, sh_channel}));
                end
                bytes_q.push_back({1'b0, note});
                bytes_q.push_back({1'b0, sh_velocity});
                push_vlq(bytes_q, 28'(arg) * 28'd30);
                bytes_q.push_back({1'b0, note});
                bytes_q.push_back(8'd0);
                sh_first_note = 1'b0;
                sh_delay = 28'd0;
                sh_pos += 16'd2;
            end else if (op >= 8'h90 && op <= 8'hBF) begin
                sequence_jump(op, arg, follow, full);
            end else if (op == OP_TRANSP_SEL) begin
                if (arg == 8'd1) sh_transpose = 8'd12;
                else if (arg == 8'd0) sh_transpose = 8'd0;
                sh_pos += 16'd2;
            end else if (op == OP_TRANSP_SET) begin
                sh_transpose = arg;
                sh_pos += 16'd2;
            end else if (op == OP_VELOCITY) begin
                sh_velocity = (int'(arg) * 10 > 120) ? 7'd120 : 7'(int'(arg) * 10);
                sh_pos += 16'd2;
            end else if (op == OP_END) begin
                sh_ended = 1'b1;
            end else begin
                sh_pos += 16'd2;
            end
        end
        n = bytes_q.size();
        if (n == 0)
            midi_expected.push_back('{1'b0, 8'd0, sh_pos, sh_ended, full, 1'b1});
        for (int k = 0; k < n; k++)
            midi_expected.push_back('{1'b1, bytes_q[k], sh_pos, sh_ended, full, k == n - 1});
    endtask

    // one input transaction with random leading idle; valid stays up between
    // back-to-back transactions and is dropped only while idling
    task automatic send_item(input logic kind, input logic [1:0] trk, input logic [15:0] start,
                             input logic [7:0] op, input logic [7:0] arg,
                             input logic [7:0] follow);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {6'd0, follow, arg, op, start, trk};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_midi_events(kind, trk, start, op, arg, follow);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (midi_expected.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_program(input logic [6:0] prog);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= prog;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sh_program = prog;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_command(input logic [7:0] op, input logic [7:0] arg,
                                input logic [7:0] follow = 8'h00);
        send_item(1'b1, 2'd0, 16'd0, op, arg, follow);
    endtask

    task automatic send_start(input logic [1:0] trk, input logic [15:0] start);
        send_item(1'b0, trk, start, 8'd0, 8'd0, 8'd0);
    endtask

    // every opcode class, field extremes and the named corner cases
    task automatic test_directed();
        write_program(7'd127);
        send_command(8'h10, 8'd4);            // command while no track is open
        send_start(2'd1, 16'hFFFE);
        send_command(8'h00, 8'hFF);           // rest, position wraps
        send_command(8'h7F, 8'hFF);           // first note with program change
        send_command(OP_TRANSP_SET, 8'h80);   // large negative transpose clamps low
        send_command(8'h05, 8'd1);
        send_command(OP_TRANSP_SEL, 8'd1);
        send_command(OP_TRANSP_SEL, 8'd7);
        send_command(OP_VELOCITY, 8'hFF);
        send_command(8'h7F, 8'd0);            // clamps high
        send_command(8'hC3, 8'hAA);           // undefined opcode skips
        send_command(8'h90, 8'd3);            // forward jump
        send_command(8'hA2, 8'hFE);           // counted repeat
        send_command(8'hA2, 8'hFE);
        send_command(8'hB0, 8'd89, 8'hFF);    // loop workaround ends track
        send_start(2'd3, 16'h0100);
        send_command(8'h02, 8'd2);            // percussion remaps
        send_command(8'h03, 8'd2);
        send_command(8'h20, 8'd2);
        for (int k = 0; k < 6; k++) send_command(8'h00, 8'hFF);
        send_command(8'h30, 8'd1);            // multi-byte delay
        send_command(8'hB0, 8'h80);           // negative jump ends
        send_start(2'd2, 16'd0);              // empty track
        send_command(OP_END, 8'd0);
    endtask

    // fills the repeat table and keeps jumping once it is full
    task automatic test_table_full();
        write_program(7'd0);
        send_start(2'd0, 16'h4000);
        for (int k = 0; k < REPEAT_ENTRIES; k++) begin
            send_command(8'h91, 8'd1);
            send_command(8'h00, 8'd0);
        end
        send_command(8'h91, 8'd1);
        send_command(8'h91, 8'd1);
        // sender holds off until all results are back
        s_axis_tvalid <= 1'b0;
        while (midi_expected.size() != 0) @(posedge i_clk);
        send_command(OP_END, 8'd0);
    endtask

    function automatic logic [7:0] random_opcode();
        case ($urandom_range(9))
            0, 1, 2: return 8'($urandom_range(8'h01, 8'h7F));
            3:       return OP_REST;
            4:       return 8'($urandom_range(8'h90, 8'hBF));
            5:       return OP_TRANSP_SEL;
            6:       return OP_TRANSP_SET;
            7:       return OP_VELOCITY;
            8:       return ($urandom_range(7) == 0) ? OP_END : 8'($urandom_range(8'h01, 8'h7F));
            default: return 8'($urandom());
        endcase
    endfunction

    task automatic test_random(input int items);
        logic [7:0] op, arg;
        for (int k = 0; k < items; k++) begin
            if (k % 18 == 0 || $urandom_range(30) == 0) begin
                send_start(2'($urandom()), ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom()));
            end else begin
                op = random_opcode();
                arg = 8'($urandom());
                if (op >= 8'h90 && op <= 8'hBF && $urandom_range(1)) arg = 8'hFF;
                if (op == OP_TRANSP_SEL) arg = 8'($urandom_range(2));
                send_command(op, arg, ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom()));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 7'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cycles = 0;
        mismatches = 0;
        send_idle_pct = 22;
        recv_idle_pct = 62;
        sh_program = 7'd0;
        sh_pos = 16'd0;
        sh_transpose = 8'd0;
        sh_velocity = VEL_RESET;
        sh_delay = 28'd0;
        sh_first_note = 1'b1;
        sh_channel = 2'd0;
        sh_ended = 1'b1;
        sh_rpt_fill = 0;
        for (int k = 0; k < REPEAT_ENTRIES; k++) sh_rpt_valid[k] = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(12);
        send_idle_pct = 62;
        recv_idle_pct = 22;
        test_table_full();
        write_program(7'($urandom_range(1, 126)));
        test_random(12);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_program(7'd5);
        test_random(12);

        wait_drained();
        if (mismatches == 0)
            $display("PASS music_sequence_to_midi_events");
        else
            $display("FAIL music_sequence_to_midi_events");
        $finish;
    end
endmodule
